// File: rtl/krm_pkg.sv
// ----------------------------------------------------------------------------
// krm_pkg: shared definitions of the k-way run merger
// Data width, register width and parameter defaults used by all files.
// ----------------------------------------------------------------------------
`default_nettype none

package krm_pkg;

   // Width of one stored element and of a merged result word.
   localparam int DATA_W = 32;

   // Width of the run count configuration register.
   localparam int RUN_COUNT_W = 4;

   // Defaults of the top level parameters.
   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int MAX_RUNS_DEF = 8;

endpackage : krm_pkg

`default_nettype wire

// File: rtl/kway_run_merger.sv
// ----------------------------------------------------------------------------
// kway_run_merger: k-way merge of presorted runs
// Loads signed words into a store, then merges run_count runs of the stored
// set into ascending order with one shared comparator.
//
//   channel   ports                                    flow control
//   request   req_start, busy, req_value, req_last_load  start while not busy
//   response  rsp_strobe, rsp_merged_value, rsp_last_out one-cycle strobe
//   config    csr_valid, csr_ready, csr_run_count        valid/ready
//
// A load that is not marked last leaves busy low.
// A marked load starts the merge: the chunk size is divided out, the run
// bounds are set up one run per cycle, and then each merged word takes one
// comparator step per run plus a drain step to close the store read
// pipeline. busy drops in the cycle that strobes the final word. Reset is
// synchronous and clears the store count.
// The receiver cannot stall, so each word is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_run_merger
   import krm_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int MAX_RUNS = MAX_RUNS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_start,
   output logic                        busy,
   input  wire logic [DATA_W-1:0]      req_value,
   input  wire logic                   req_last_load,
   output logic                        rsp_strobe,
   output logic      [DATA_W-1:0]      rsp_merged_value,
   output logic                        rsp_last_out,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [RUN_COUNT_W-1:0] csr_run_count
);

   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int RUN_W  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int RCNT_W = $clog2(MAX_RUNS + 1);
   localparam int DIV_W  = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type               state_ff, state_in;
   logic [RUN_COUNT_W-1:0]  run_count_ff;
   logic [CNT_W-1:0]        load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [RCNT_W-1:0]       runs_ff, runs_in;
   logic [CNT_W-1:0]        chunk_ff, chunk_in;
   logic [CNT_W-1:0]        acc_ff, acc_in;
   logic [RUN_W-1:0]        run_idx_ff, run_idx_in;
   logic [CNT_W-1:0]        out_cnt_ff, out_cnt_in;
   logic                    p_valid_ff, p_valid_in;
   logic [RUN_W-1:0]        p_run_ff, p_run_in;
   logic [CNT_W-1:0]        p_head_ff, p_head_in;
   logic                    found_ff, found_in;
   logic [DATA_W-1:0]       best_val_ff, best_val_in;
   logic [RUN_W-1:0]        best_run_ff, best_run_in;
   logic [CNT_W-1:0]        best_head_ff, best_head_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]        heads_ff [MAX_RUNS];
   logic [CNT_W-1:0]        ends_ff [MAX_RUNS];

   logic                    load_accept;
   logic                    room;
   logic [CNT_W-1:0]        total_new;
   logic [RCNT_W-1:0]       runs_eff;
   logic                    last_run;
   logic                    store_we;
   logic [DATA_W-1:0]       rd_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    div_start;
   logic                    div_done;
   logic [DIV_W-1:0]        div_quotient;
   logic                    cmp_take;
   logic [DATA_W-1:0]       cand_val;
   logic [RUN_W-1:0]        cand_run;
   logic [CNT_W-1:0]        cand_head;
   logic                    setup_we;
   logic [CNT_W-1:0]        setup_end;
   logic                    head_inc_we;

   // Configuration register; zero means one run, large values saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= RUN_COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         run_count_ff <= csr_run_count;
      end
   end

   assign csr_ready = 1'b1;
   assign runs_eff  = (run_count_ff == '0) ? RCNT_W'(1) :
                      ((32'(run_count_ff) > MAX_RUNS) ? RCNT_W'(MAX_RUNS) :
                                                        RCNT_W'(run_count_ff));

   // Element store, written by loads and read at the head of the scanned run.
   assign rd_addr = heads_ff[run_idx_ff][ADDR_W-1:0];

   krm_store #(
      .DEPTH   (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (load_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Chunk size: stored total divided by the effective run count.
   krm_div #(
      .WIDTH    (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(total_new)),
      .divisor  (DIV_W'(runs_eff)),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Shared signed comparator: does the word just read beat the best so far?
   assign cmp_take  = p_valid_ff &&
                      (!found_ff || ($signed(rd_data) < $signed(best_val_ff)));
   assign cand_val  = cmp_take ? rd_data : best_val_ff;
   assign cand_run  = cmp_take ? p_run_ff : best_run_ff;
   assign cand_head = cmp_take ? p_head_ff : best_head_ff;

   assign load_accept = req_start && (state_ff == ST_IDLE);
   assign room        = load_cnt_ff < CNT_W'(MAX_ELEMENTS);
   assign total_new   = room ? (load_cnt_ff + 1'b1) : load_cnt_ff;
   assign last_run    = (RCNT_W'(run_idx_ff) == (runs_ff - 1'b1));
   assign setup_end   = last_run ? total_ff : (acc_ff + chunk_ff);

   // Sequencer: load, divide, set up run bounds, then scan and emit.
   always_comb begin
      state_in      = state_ff;
      load_cnt_in   = load_cnt_ff;
      total_in      = total_ff;
      runs_in       = runs_ff;
      chunk_in      = chunk_ff;
      acc_in        = acc_ff;
      run_idx_in    = run_idx_ff;
      out_cnt_in    = out_cnt_ff;
      p_valid_in    = 1'b0;
      p_run_in      = p_run_ff;
      p_head_in     = p_head_ff;
      found_in      = found_ff;
      best_val_in   = best_val_ff;
      best_run_in   = best_run_ff;
      best_head_in  = best_head_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      store_we      = 1'b0;
      div_start     = 1'b0;
      setup_we      = 1'b0;
      head_inc_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (load_accept) begin
               store_we    = room;
               load_cnt_in = total_new;
               if (req_last_load) begin
                  total_in  = total_new;
                  runs_in   = runs_eff;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               chunk_in   = div_quotient[CNT_W-1:0];
               acc_in     = '0;
               run_idx_in = '0;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            setup_we = 1'b1;
            acc_in   = acc_ff + chunk_ff;
            if (last_run) begin
               run_idx_in = '0;
               out_cnt_in = '0;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end else begin
               run_idx_in = run_idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            // Issue the head of this run and compare the one issued before.
            p_valid_in   = heads_ff[run_idx_ff] < ends_ff[run_idx_ff];
            p_run_in     = run_idx_ff;
            p_head_in    = heads_ff[run_idx_ff];
            found_in     = found_ff || cmp_take;
            best_val_in  = cand_val;
            best_run_in  = cand_run;
            best_head_in = cand_head;
            if (last_run) begin
               state_in = ST_DRAIN;
            end else begin
               run_idx_in = run_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Last compare done: emit the winner and advance its run.
            head_inc_we   = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = cand_val;
            rsp_last_in   = (out_cnt_ff == (total_ff - 1'b1));
            found_in      = 1'b0;
            run_idx_in    = '0;
            if (out_cnt_ff == (total_ff - 1'b1)) begin
               load_cnt_in = '0;
               state_in    = ST_IDLE;
            end else begin
               out_cnt_in = out_cnt_ff + 1'b1;
               state_in   = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and registered response word.
   always_ff @(posedge clock) begin
      total_ff     <= total_in;
      runs_ff      <= runs_in;
      chunk_ff     <= chunk_in;
      acc_ff       <= acc_in;
      run_idx_ff   <= run_idx_in;
      out_cnt_ff   <= out_cnt_in;
      p_run_ff     <= p_run_in;
      p_head_ff    <= p_head_in;
      best_val_ff  <= best_val_in;
      best_run_ff  <= best_run_in;
      best_head_ff <= best_head_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_cnt_ff   <= '0;
         p_valid_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_cnt_ff   <= load_cnt_in;
         p_valid_ff    <= p_valid_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Run head and end registers, set up per run and advanced on each output.
   always_ff @(posedge clock) begin
      if (setup_we) begin
         heads_ff[run_idx_ff] <= acc_ff;
         ends_ff[run_idx_ff]  <= setup_end;
      end else if (head_inc_we) begin
         heads_ff[cand_run] <= cand_head + 1'b1;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule : kway_run_merger

`default_nettype wire

// File: rtl/krm_store.sv
// ----------------------------------------------------------------------------
// krm_store: element memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module krm_store
   import krm_pkg::*;
#(
   parameter int DEPTH = MAX_ELEMENTS_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : krm_store

`default_nettype wire

// File: rtl/krm_div.sv
// ----------------------------------------------------------------------------
// krm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module krm_div
   import krm_pkg::*;
#(
   parameter int WIDTH = 8,
   localparam int CNT_W = $clog2(WIDTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient
);

   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_W'(WIDTH);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : krm_div

`default_nettype wire

// File: tb/kway_run_merger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_run_merger_test: self-checking testbench of the k-way run merger
// Loads sets of signed words and checks every merged word against a local
// merge of the same set. The stimulus covers presorted and unsorted runs,
// ties, empty runs, store overflow and run counts from 0 to 15.
// ----------------------------------------------------------------------------

// One merged word as the block strobes it out.
typedef struct packed {
   logic [krm_pkg::DATA_W-1:0] value;
   logic                        last_word;
} merged_word_type;

// Keeps its own copy of the element store and run count, merges each set when
// its marked load is accepted, and checks the strobed words in order.
class run_merge_tracker;
   logic [krm_pkg::DATA_W-1:0]      element_store [krm_pkg::MAX_ELEMENTS_DEF];
   int unsigned                     load_count;
   logic [krm_pkg::RUN_COUNT_W-1:0] run_count;
   merged_word_type                 pending_words [$];
   int                              failures;
   int                              loads_seen;
   int                              sets_merged;
   int                              words_checked;

   function new();
      load_count = 0;
      run_count = 1;
      failures = 0;
      loads_seen = 0;
      sets_merged = 0;
      words_checked = 0;
   endfunction

   function void set_run_count(logic [krm_pkg::RUN_COUNT_W-1:0] value);
      run_count = value;
   endfunction

   function int pending();
      return pending_words.size();
   endfunction

   // Store one accepted load; a marked load merges the whole set.
   function void note_load(logic [krm_pkg::DATA_W-1:0] value, logic last_load);
      int unsigned                runs;
      int unsigned                chunk;
      int unsigned                total;
      int unsigned                best_run;
      int unsigned                heads [krm_pkg::MAX_RUNS_DEF];
      int unsigned                ends [krm_pkg::MAX_RUNS_DEF];
      logic [krm_pkg::DATA_W-1:0] best;
      bit                         found;
      merged_word_type            word;

      loads_seen++;
      // Loads that find the store full are dropped.
      if (load_count < krm_pkg::MAX_ELEMENTS_DEF) begin
         element_store[load_count] = value;
         load_count++;
      end
      if (!last_load)
         return;

      // A run count of zero means one run; large counts saturate.
      runs = run_count;
      if (runs == 0)
         runs = 1;
      if (runs > krm_pkg::MAX_RUNS_DEF)
         runs = krm_pkg::MAX_RUNS_DEF;
      total = load_count;
      chunk = total / runs;
      for (int unsigned i = 0; i < runs; i++) begin
         heads[i] = i * chunk;
         ends[i] = (i == runs - 1) ? total : (i + 1) * chunk;
      end

      // Smallest head wins; the strict compare keeps the lowest run on a tie.
      for (int unsigned k = 0; k < total; k++) begin
         found = 1'b0;
         best = '0;
         best_run = 0;
         for (int unsigned i = 0; i < runs; i++) begin
            if (heads[i] < ends[i]) begin
               if (!found || $signed(element_store[heads[i]]) < $signed(best)) begin
                  best = element_store[heads[i]];
                  best_run = i;
                  found = 1'b1;
               end
            end
         end
         if (found)
            heads[best_run]++;
         word.value = best;
         word.last_word = (k == total - 1);
         pending_words.push_back(word);
      end
      load_count = 0;
      sets_merged++;
   endfunction

   function void report_mismatch(string what, merged_word_type want,
                                 logic [krm_pkg::DATA_W-1:0] value, logic last_word);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: expected value %0d last %0b, got value %0d last %0b",
                  $time, what, $signed(want.value), want.last_word,
                  $signed(value), last_word);
   endfunction

   // Compare one strobed word with the oldest expected word.
   function void check_word(logic [krm_pkg::DATA_W-1:0] value, logic last_word);
      merged_word_type want;

      if (pending_words.size() == 0) begin
         want = '0;
         report_mismatch("merged word with none expected", want, value, last_word);
         return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (want.value !== value || want.last_word !== last_word)
         report_mismatch("merged word mismatch", want, value, last_word);
   endfunction

   function void close_out();
      if (pending_words.size() != 0) begin
         failures += pending_words.size();
         $display("%0d merged words still expected at end of run", pending_words.size());
      end
   endfunction
endclass

module kway_run_merger_test;
   import krm_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_ITEMS = 80;
   localparam int PHASE_ITEMS = 70;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS = 4_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_start = 1'b0;
   logic [DATA_W-1:0]      req_value = '0;
   logic                   req_last_load = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [RUN_COUNT_W-1:0] csr_run_count = '0;
   logic                   busy;
   logic                   rsp_strobe;
   logic [DATA_W-1:0]      rsp_merged_value;
   logic                   rsp_last_out;
   logic                   csr_ready;

   run_merge_tracker       merge_tracker;
   logic [RUN_COUNT_W-1:0] cur_run_count = 1;
   int                     items_sent = 0;
   int                     config_writes = 0;

   kway_run_merger #(
      .MAX_ELEMENTS(MAX_ELEMENTS_DEF),
      .MAX_RUNS(MAX_RUNS_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .busy(busy),
      .req_value(req_value),
      .req_last_load(req_last_load),
      .rsp_strobe(rsp_strobe),
      .rsp_merged_value(rsp_merged_value),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_run_count(csr_run_count)
   );

   always #CLOCK_HALF clock = ~clock;

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            merge_tracker.check_word(rsp_merged_value, rsp_last_out);
         if (req_start && !busy)
            merge_tracker.note_load(req_value, req_last_load);
         if (csr_valid && csr_ready)
            merge_tracker.set_run_count(csr_run_count);
      end
   end

   // Present one load word and hold it until the block takes it.
   task automatic load_word(input logic [DATA_W-1:0] value, input logic last_load);
      req_value <= value;
      req_last_load <= last_load;
      req_start <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off the sender until every expected word has come back.
   task automatic drain_results();
      req_start <= 1'b0;
      @(posedge clock);
      while (merge_tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_run_count(input logic [RUN_COUNT_W-1:0] value);
      csr_run_count <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      cur_run_count = value;
      config_writes++;
   endtask

   // Mix of full-range values, a narrow band that forces ties, and extremes.
   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 15) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Send one set; when presorted, each run of the current split is sorted.
   task automatic merge_set(input int length, input bit presorted, input bit idling);
      int values [$];
      int segment [$];
      int runs;
      int total;
      int chunk;
      int lo;
      int hi;

      for (int i = 0; i < length; i++)
         values.push_back(int'(random_value()));
      if (presorted) begin
         runs = (cur_run_count == 0) ? 1 :
                (cur_run_count > MAX_RUNS_DEF) ? MAX_RUNS_DEF : int'(cur_run_count);
         total = (length < MAX_ELEMENTS_DEF) ? length : MAX_ELEMENTS_DEF;
         chunk = total / runs;
         for (int r = 0; r < runs; r++) begin
            lo = r * chunk;
            hi = (r == runs - 1) ? total : lo + chunk;
            if (hi > lo) begin
               segment = values[lo:hi-1];
               segment.sort();
               for (int j = 0; j < hi - lo; j++)
                  values[lo + j] = segment[j];
            end
         end
      end
      for (int i = 0; i < length; i++) begin
         load_word(values[i], i == length - 1);
         // Loads past a full store are dropped and do not count, but the marked last load does.
         if (i < MAX_ELEMENTS_DEF || i == length - 1)
            items_sent++;
         if (idling && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 18));
      end
   endtask

   initial begin
      logic [RUN_COUNT_W-1:0] phase_counts [6];
      logic [RUN_COUNT_W-1:0] rc;
      int                     length;
      int                     phase;
      int                     phase_start;
      bit                     idling;

      phase_counts = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd9, 4'd4};
      merge_tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Single most negative word at the reset run count.
      load_word(32'h8000_0000, 1'b1);
      drain_results();

      // Run count zero behaves as one run.
      write_run_count(4'd0);
      load_word(32'h7fff_ffff, 1'b0);
      load_word(32'hffff_ffff, 1'b0);
      load_word(32'h0000_0000, 1'b1);
      drain_results();

      // More runs than elements: all but the last run are empty.
      write_run_count(4'd15);
      load_word(32'd3, 1'b0);
      load_word(32'd1, 1'b0);
      load_word(32'd2, 1'b1);
      drain_results();

      // Equal heads in two runs: the lower run goes first.
      write_run_count(4'd2);
      load_word(32'd5, 1'b0);
      load_word(32'd9, 1'b0);
      load_word(32'd5, 1'b0);
      load_word(32'd9, 1'b1);
      drain_results();

      // Eight runs of one word each, extremes among them.
      write_run_count(4'd8);
      load_word(32'd4, 1'b0);
      load_word(-32'sd3, 1'b0);
      load_word(32'd7, 1'b0);
      load_word(-32'sd3, 1'b0);
      load_word(32'd0, 1'b0);
      load_word(32'h8000_0000, 1'b0);
      load_word(32'h7fff_ffff, 1'b0);
      load_word(32'd1, 1'b1);
      drain_results();

      // Uneven split: the last run takes the remainder.
      write_run_count(4'd3);
      load_word(-32'sd7, 1'b0);
      load_word(32'd2, 1'b0);
      load_word(-32'sd7, 1'b0);
      load_word(32'd2, 1'b0);
      load_word(32'h8000_0000, 1'b1);
      drain_results();

      // Random phases, each at its own run count; the tail runs without gaps,
      // so the phase that reaches it carries on to the end.
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         rc = (phase < 6) ? phase_counts[phase] : RUN_COUNT_W'($urandom_range(0, 15));
         write_run_count(rc);
         phase_start = items_sent;
         while ((items_sent - phase_start < PHASE_ITEMS ||
                 items_sent >= RANDOM_ITEMS - CALM_ITEMS) &&
                items_sent < RANDOM_ITEMS) begin
            idling = items_sent < RANDOM_ITEMS - CALM_ITEMS;
            case ($urandom_range(0, 19))
               0: length = $urandom_range(MAX_ELEMENTS_DEF + 1, MAX_ELEMENTS_DEF + 6);
               1, 2: length = $urandom_range(13, MAX_ELEMENTS_DEF);
               3: length = MAX_ELEMENTS_DEF;
               default: length = $urandom_range(1, 12);
            endcase
            merge_set(length, $urandom_range(0, 3) != 0, idling);
            if (idling && $urandom_range(0, 7) == 0)
               drain_results();
         end
         drain_results();
         phase++;
      end

      merge_tracker.close_out();
      $display("Covered %0d loads in %0d merged sets, %0d merged words checked.",
               merge_tracker.loads_seen, merge_tracker.sets_merged,
               merge_tracker.words_checked);
      $display("Run count written %0d times over directed cases and %0d random phases.",
               config_writes, phase);
      if (merge_tracker.failures == 0)
         $display("kway_run_merger test passed");
      else
         $display("kway_run_merger test failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #TIMEOUT_NS;
      $display("kway_run_merger test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/krm_pkg.sv
rtl/krm_store.sv
rtl/krm_div.sv
rtl/kway_run_merger.sv
tb/kway_run_merger_test.sv
